/* rtl/fault_waveform_generator_defines.svh */
// Assertion macros for the fault waveform generator.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef FAULT_WAVEFORM_GENERATOR_DEFINES_SVH
`define FAULT_WAVEFORM_GENERATOR_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define FWG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fault waveform generator: same-cycle check failed");
// Next-cycle implication, checked out of reset
`define FWG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fault waveform generator: next-cycle check failed");
`else
`define FWG_ASSERT_NOW(label, ante, cons)
`define FWG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/fwg_pkg.sv */
// Shared types, register codes and the sine table function for the fault waveform generator.
// No dependencies; every RTL module refers to it by scoped names.
package fwg_pkg;

	localparam int unsigned FRAME_LEN_DEF       = 16;
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;
	localparam int unsigned CFG_DATA_W          = 32;
	localparam int unsigned CFG_INDEX_W         = 3;
	localparam int unsigned CORDIC_STEPS        = 24;
	localparam longint      CORDIC_X0           = 64'sd1304025956;

	// arctan(2^-i) on a 2^32 turn
	localparam longint CORDIC_ATAN [CORDIC_STEPS] = '{
		64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
		64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
		64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
		64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861,
		64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304,
		64'sd652, 64'sd326, 64'sd163, 64'sd81
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PHASE_STEP_PRE  = 3'd0,
		REG_PHASE_STEP_POST = 3'd1,
		REG_PHASE_OFFSETS   = 3'd2,
		REG_AMPLITUDES      = 3'd3,
		REG_EXP_INITIAL     = 3'd4,
		REG_EXP_DECAY       = 3'd5,
		REG_START_TICKS     = 3'd6,
		REG_FAULT_TICKS     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] phase_step_pre;
		logic [31:0] phase_step_post;
		logic [31:0] phase_offsets;
		logic [31:0] amplitudes;
		logic [17:0] exp_initial;
		logic [15:0] exp_decay;
		logic [31:0] start_ticks;
		logic [31:0] fault_ticks;
	} cfg_t;

	// Per-sample side information carried alongside the table lookup
	typedef struct packed {
		logic        active;
		logic        fault;
		logic        last;
		logic [17:0] offset;
	} item_info_t;

	// Sine of table entry k in Q1.15, by 24-step integer CORDIC; elaboration only
	function automatic logic signed [15:0] sine_entry(input int unsigned k,
			input int unsigned tbits);
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		longint r;
		z = longint'(k) << (32 - tbits);
		x = CORDIC_X0;
		y = 0;
		if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
		if (z > 64'sd1073741824) z = 64'sd2147483648 - z;
		else if (z < -64'sd1073741824) z = -64'sd2147483648 - z;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - CORDIC_ATAN[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + CORDIC_ATAN[i];
			end
		end
		r = (y + 64'sd32768) >>> 16;
		if (r > 64'sd32767) r = 64'sd32767;
		if (r < -64'sd32767) r = -64'sd32767;
		return r[15:0];
	endfunction

endpackage

/* rtl/fwg_sine_rom.sv */
// Sine lookup ROM with registered read, filled at elaboration.
// Depends on fwg_pkg for the table function.
module fwg_sine_rom #(
	parameter int unsigned ADDR_W = fwg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ADDR_W-1:0]        addr,
	output logic signed [15:0]       data
);

	localparam int unsigned DEPTH = 2 ** ADDR_W;

	logic signed [15:0] rom [DEPTH];

	// Build the table from constants
	for (genvar g = 0; g < DEPTH; g++) begin : g_entry
		localparam logic signed [15:0] VAL = fwg_pkg::sine_entry(g, ADDR_W);
		assign rom[g] = VAL;
	end

	// Registered read, held while the stage stalls
	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom[addr];
		end
	end

endmodule

/* rtl/fwg_front.sv */
// Front stage: phase accumulator, tick counter, decaying offset and frame counter.
// Depends on fwg_pkg; feeds the table address and side information to stage 1.
module fwg_front #(
	parameter int unsigned FRAME_LEN       = fwg_pkg::FRAME_LEN_DEF,
	parameter int unsigned SINE_TABLE_BITS = fwg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fwg_pkg::cfg_t               cfg,
	input  logic                        accept,
	input  logic                        restart,
	output logic [SINE_TABLE_BITS-1:0]  k_s1,
	output logic [15:0]                 amp_s1,
	output fwg_pkg::item_info_t         info_s1
);

	localparam int unsigned FP_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
	localparam logic [FP_W-1:0] FP_LAST = FP_W'(FRAME_LEN - 1);

	logic [31:0]     phase_q;
	logic [31:0]     elapsed_q;
	logic [17:0]     offset_q;
	logic [FP_W-1:0] frame_pos_q;

	logic [31:0] phase_v;
	logic [31:0] elapsed_v;
	logic [17:0] offset_v;
	logic [31:0] onset;
	logic        active;
	logic        fault;
	logic        last;
	logic [15:0] ang;
	logic [15:0] amp;
	logic [17:0] off_used;
	logic [17:0] mag;
	logic [33:0] mag_prod;
	logic [17:0] mag_dec;
	logic [17:0] off_next;

	// Apply restart ahead of this sample
	always_comb begin
		phase_v   = restart ? 32'd0 : phase_q;
		elapsed_v = restart ? 32'd0 : elapsed_q;
		offset_v  = restart ? 18'd0 : offset_q;
	end

	// Region decode and table angle
	always_comb begin
		onset  = (cfg.fault_ticks > cfg.start_ticks) ? cfg.fault_ticks : cfg.start_ticks;
		active = elapsed_v >= cfg.start_ticks;
		fault  = active && (elapsed_v >= cfg.fault_ticks);
		ang    = phase_v[31:16] + cfg.phase_offsets[15:0]
			+ (fault ? cfg.phase_offsets[31:16] : 16'd0);
		amp    = fault ? cfg.amplitudes[31:16] : cfg.amplitudes[15:0];
		last   = frame_pos_q == FP_LAST;
	end

	// Seed at onset, then shrink the magnitude by the decay factor
	always_comb begin
		off_used = (elapsed_v == onset) ? cfg.exp_initial : offset_v;
		mag      = off_used[17] ? (~off_used + 18'd1) : off_used;
		mag_prod = mag * cfg.exp_decay;
		mag_dec  = mag_prod[33:16];
		off_next = off_used[17] ? (~mag_dec + 18'd1) : mag_dec;
	end

	// Advance the state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			elapsed_q   <= '0;
			offset_q    <= '0;
			frame_pos_q <= '0;
		end else if (accept) begin
			if (active) begin
				phase_q <= phase_v + (fault ? cfg.phase_step_post : cfg.phase_step_pre);
			end else begin
				phase_q <= phase_v;
			end
			offset_q    <= fault ? off_next : offset_v;
			elapsed_q   <= (elapsed_v == 32'hFFFF_FFFF) ? elapsed_v : elapsed_v + 32'd1;
			frame_pos_q <= last ? '0 : frame_pos_q + FP_W'(1);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			k_s1           <= ang[15 -: SINE_TABLE_BITS];
			amp_s1         <= amp;
			info_s1.active <= active;
			info_s1.fault  <= fault;
			info_s1.last   <= last;
			info_s1.offset <= off_used;
		end
	end

endmodule

/* rtl/fwg_back.sv */
// Back stages: amplitude scaling, rounding, offset add and 16-bit saturation.
// Depends on fwg_pkg; takes the ROM output aligned with stage 2 side information.
module fwg_back (
	input  logic                 clk,
	input  logic                 en_s2,
	input  logic                 en_s3,
	input  logic                 en_out,
	input  logic [15:0]          amp_s1,
	input  fwg_pkg::item_info_t  info_s1,
	input  logic signed [15:0]   sine_s2,
	output logic signed [15:0]   sample_q,
	output logic                 in_fault_q,
	output logic                 frame_last_q
);

	logic [15:0]          amp_s2;
	fwg_pkg::item_info_t  info_s2;
	logic signed [32:0]   prod_s3;
	fwg_pkg::item_info_t  info_s3;

	logic signed [33:0]   rnd_w;
	logic signed [33:0]   rnd_sh;
	logic signed [17:0]   rnd;
	logic signed [19:0]   sum;
	logic signed [15:0]   sample_d;

	// Stage 2: hold side information beside the table read
	always_ff @(posedge clk) begin
		if (en_s2) begin
			amp_s2  <= amp_s1;
			info_s2 <= info_s1;
		end
	end

	// Stage 3: scale by amplitude
	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3 <= sine_s2 * $signed({1'b0, amp_s2});
			info_s3 <= info_s2;
		end
	end

	// Round Q1.15 product, add offset, saturate
	always_comb begin
		rnd_w  = {prod_s3[32], prod_s3} + 34'sd16384;
		rnd_sh = rnd_w >>> 15;
		rnd    = rnd_sh[17:0];
		sum    = {{2{rnd[17]}}, rnd}
			+ (info_s3.fault ? {{2{info_s3.offset[17]}}, $signed(info_s3.offset)} : 20'sd0);
		if (!info_s3.active) begin
			sample_d = 16'sd0;
		end else if (sum > 20'sd32767) begin
			sample_d = 16'sh7FFF;
		end else if (sum < -20'sd32768) begin
			sample_d = 16'sh8000;
		end else begin
			sample_d = sum[15:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en_out) begin
			sample_q     <= sample_d;
			in_fault_q   <= info_s3.fault;
			frame_last_q <= info_s3.last;
		end
	end

endmodule

/* rtl/fault_waveform_generator.sv */
// Fault waveform generator: one signed 16-bit sample per accepted input beat, zero before
// start_ticks, a table sine at the pre-fault settings until fault_ticks, then the post-fault
// sine plus an exponentially decaying offset, saturated to 16 bits. It takes one beat per
// clock while the output is not stalled; phase, tick count and offset update on acceptance,
// so the rate is one sample per cycle under that condition. A result passes four register
// stages (state/address stage, registered sine ROM, amplitude multiply, round-add-saturate
// output register), the first loaded on the accepting edge. Beats keep flowing into empty
// stages while a finished sample waits at the output. The sine ROM holds 2^SINE_TABLE_BITS
// entries built at elaboration. Write configuration only while the block is idle.
// Depends on fwg_pkg, fwg_front, fwg_sine_rom, fwg_back and the assertion macro header.
`include "fault_waveform_generator_defines.svh"

module fault_waveform_generator #(
	parameter int unsigned FRAME_LEN       = fwg_pkg::FRAME_LEN_DEF,
	parameter int unsigned SINE_TABLE_BITS = fwg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [fwg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fwg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [15:0]                sample,
	output logic                              in_fault,
	output logic                              frame_last
);

	fwg_pkg::cfg_t        cfg_q;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	logic                 out_valid_q;
	logic                 ready_out;
	logic                 ready_s3;
	logic                 ready_s2;
	logic                 ready_s1;
	logic                 accept;

	logic [SINE_TABLE_BITS-1:0] k_s1;
	logic [15:0]                amp_s1;
	fwg_pkg::item_info_t        info_s1;
	logic signed [15:0]         sine_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (fwg_pkg::cfg_reg_t'(cfg_index))
				fwg_pkg::REG_PHASE_STEP_PRE:  cfg_q.phase_step_pre  <= cfg_data;
				fwg_pkg::REG_PHASE_STEP_POST: cfg_q.phase_step_post <= cfg_data;
				fwg_pkg::REG_PHASE_OFFSETS:   cfg_q.phase_offsets   <= cfg_data;
				fwg_pkg::REG_AMPLITUDES:      cfg_q.amplitudes      <= cfg_data;
				fwg_pkg::REG_EXP_INITIAL:     cfg_q.exp_initial     <= cfg_data[17:0];
				fwg_pkg::REG_EXP_DECAY:       cfg_q.exp_decay       <= cfg_data[15:0];
				fwg_pkg::REG_START_TICKS:     cfg_q.start_ticks     <= cfg_data;
				fwg_pkg::REG_FAULT_TICKS:     cfg_q.fault_ticks     <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or its content moves on
	always_comb begin
		ready_out = !out_valid_q || out_ready;
		ready_s3  = !valid_s3 || ready_out;
		ready_s2  = !valid_s2 || ready_s3;
		ready_s1  = !valid_s1 || ready_s2;
		accept    = in_valid && ready_s1;
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1)  valid_s1    <= in_valid;
			if (ready_s2)  valid_s2    <= valid_s1;
			if (ready_s3)  valid_s3    <= valid_s2;
			if (ready_out) out_valid_q <= valid_s3;
		end
	end

	fwg_front #(
		.FRAME_LEN       (FRAME_LEN),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.restart (restart),
		.k_s1    (k_s1),
		.amp_s1  (amp_s1),
		.info_s1 (info_s1)
	);

	fwg_sine_rom #(
		.ADDR_W (SINE_TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.en   (ready_s2),
		.addr (k_s1),
		.data (sine_s2)
	);

	fwg_back u_back (
		.clk          (clk),
		.en_s2        (ready_s2),
		.en_s3        (ready_s3),
		.en_out       (ready_out),
		.amp_s1       (amp_s1),
		.info_s1      (info_s1),
		.sine_s2      (sine_s2),
		.sample_q     (sample),
		.in_fault_q   (in_fault),
		.frame_last_q (frame_last)
	);

	assign in_ready  = ready_s1;
	assign out_valid = out_valid_q;

	// Input stalls only behind a blocked output beat
	`FWG_ASSERT_NOW(a_stall_from_output, !in_ready, out_valid && !out_ready)
	// An accepted beat lands in stage 1
	`FWG_ASSERT_NEXT(a_accept_lands, accept, valid_s1)
	// The post-fault flag only ever rides on an active sample
	`FWG_ASSERT_NOW(a_fault_needs_active, valid_s1 && info_s1.fault, info_s1.active)

endmodule
